/* src/xysp_pkg.sv */
// ----------------------------------------------------------------------------
// xysp_pkg
// Shared constants and the sine lookup for the 2D speed P controller with
// body-frame rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xysp_pkg;

   localparam int GAIN_BITS = 16;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

   localparam int TRIG_BITS = 16;   // Q1.14 with sign
   localparam int STEP_BITS = 8;

   typedef logic signed [TRIG_BITS-1:0] trig_type;
   typedef logic [STEP_BITS-1:0] step_type;

   localparam trig_type QUARTER_SINE [0:64] = '{
      16'sd0,     16'sd402,   16'sd804,   16'sd1205,  16'sd1606,  16'sd2006,
      16'sd2404,  16'sd2801,  16'sd3196,  16'sd3590,  16'sd3981,  16'sd4370,
      16'sd4756,  16'sd5139,  16'sd5520,  16'sd5897,  16'sd6270,  16'sd6639,
      16'sd7005,  16'sd7366,  16'sd7723,  16'sd8076,  16'sd8423,  16'sd8765,
      16'sd9102,  16'sd9434,  16'sd9760,  16'sd10080, 16'sd10394, 16'sd10702,
      16'sd11003, 16'sd11297, 16'sd11585, 16'sd11866, 16'sd12140, 16'sd12406,
      16'sd12665, 16'sd12916, 16'sd13160, 16'sd13395, 16'sd13623, 16'sd13842,
      16'sd14053, 16'sd14256, 16'sd14449, 16'sd14635, 16'sd14811, 16'sd14978,
      16'sd15137, 16'sd15286, 16'sd15426, 16'sd15557, 16'sd15679, 16'sd15791,
      16'sd15893, 16'sd15986, 16'sd16069, 16'sd16143, 16'sd16207, 16'sd16261,
      16'sd16305, 16'sd16340, 16'sd16364, 16'sd16379, 16'sd16384
   };

   function automatic trig_type sine_of_step(input step_type step);
      logic [1:0] quad;
      logic [5:0] r;
      logic [6:0] idx;
      trig_type   mag;
      quad = step[7:6];
      r    = step[5:0];
      idx  = quad[0] ? (7'd64 - {1'b0, r}) : {1'b0, r};
      mag  = QUARTER_SINE[idx];
      return quad[1] ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

/* src/xy_speed_p_control_rotate_top.sv */
// ----------------------------------------------------------------------------
// xy_speed_p_control_rotate_top
// Proportional speed controller: gain * (setpoint - measured), rotated by yaw
// into body-frame commands, saturated, with a clip flag.
//
//   channel   ports                      handshake
//   request   start, busy, req_*         start && !busy
//   response  rsp_valid, rsp_*           one-cycle strobe, no backpressure
//   config    csr_valid, csr_ready,      csr_valid && csr_ready
//             csr_speed_gain
//
// Five register stages: error + trig lookup, gain multiply, round/saturate,
// rotation multiplies, sum/round/saturate. One item per cycle. busy stays low
// since nothing downstream can stall.
// Synchronous reset clears the stage valids and sets the gain to 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xy_speed_p_control_rotate_top #(
   parameter int ANGLE_BITS = 16,
   parameter int DATA_BITS  = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  signed [DATA_BITS-1:0]           req_setpoint_x,
   input  wire  signed [DATA_BITS-1:0]           req_setpoint_y,
   input  wire  signed [DATA_BITS-1:0]           req_measured_x,
   input  wire  signed [DATA_BITS-1:0]           req_measured_y,
   input  wire         [ANGLE_BITS-1:0]          req_yaw_angle,
   output logic                                  rsp_valid,
   output logic signed [DATA_BITS-1:0]           rsp_command_x,
   output logic signed [DATA_BITS-1:0]           rsp_command_y,
   output logic                                  rsp_clipped,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire         [xysp_pkg::GAIN_BITS-1:0] csr_speed_gain
);

   localparam int EW = DATA_BITS + 1;                    // error
   localparam int PW = EW + xysp_pkg::GAIN_BITS + 1;     // gain product
   localparam int SW = DATA_BITS + 10;                   // saturation input
   localparam int RW = DATA_BITS + xysp_pkg::TRIG_BITS;  // rotation product
   localparam int CW = RW + 1;                           // rotation sum
   localparam logic signed [PW-1:0] T_ROUND = PW'(128);
   localparam logic signed [CW-1:0] C_ROUND = CW'(8192);

   function automatic logic [DATA_BITS:0] saturate(input logic signed [SW-1:0] v);
      logic [SW-DATA_BITS:0]  upper;
      logic                   ovf;
      logic [DATA_BITS-1:0]   val;
      upper = v[SW-1:DATA_BITS-1];
      ovf   = (|upper) && !(&upper);
      if (!ovf)
         val = v[DATA_BITS-1:0];
      else if (v[SW-1])
         val = {1'b1, {(DATA_BITS-1){1'b0}}};
      else
         val = {1'b0, {(DATA_BITS-1){1'b1}}};
      return {ovf, val};
   endfunction

   logic [xysp_pkg::GAIN_BITS-1:0] gain_ff;

   logic [5:1] valid_ff;

   logic signed [EW-1:0]     ex1_ff, ey1_ff;
   xysp_pkg::trig_type       sin1_ff, cos1_ff;
   logic signed [PW-1:0]     px2_ff, py2_ff;
   xysp_pkg::trig_type       sin2_ff, cos2_ff;
   logic signed [DATA_BITS-1:0] tx3_ff, ty3_ff;
   logic                     clip3_ff;
   xysp_pkg::trig_type       sin3_ff, cos3_ff;
   logic signed [RW-1:0]     txc4_ff, tys4_ff, txs4_ff, tyc4_ff;
   logic                     clip4_ff;
   logic signed [DATA_BITS-1:0] cx5_ff, cy5_ff;
   logic                     clip5_ff;

   xysp_pkg::step_type       step_in;
   logic signed [PW-1:0]     tsum_x, tsum_y;
   logic [DATA_BITS:0]       tsat_x, tsat_y;
   logic signed [CW-1:0]     csum_x, csum_y;
   logic signed [DATA_BITS+2:0] cshift_x, cshift_y;
   logic [DATA_BITS:0]       csat_x, csat_y;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= xysp_pkg::GAIN_RESET;
         valid_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            gain_ff <= csr_speed_gain;
         end
         valid_ff <= {valid_ff[4:1], start && !busy};
      end
   end

   // stage 1: error and trig lookup
   assign step_in = req_yaw_angle[ANGLE_BITS-1 -: xysp_pkg::STEP_BITS];

   always_ff @(posedge clock) begin
      ex1_ff  <= {req_setpoint_x[DATA_BITS-1], req_setpoint_x}
               - {req_measured_x[DATA_BITS-1], req_measured_x};
      ey1_ff  <= {req_setpoint_y[DATA_BITS-1], req_setpoint_y}
               - {req_measured_y[DATA_BITS-1], req_measured_y};
      sin1_ff <= xysp_pkg::sine_of_step(step_in);
      cos1_ff <= xysp_pkg::sine_of_step(step_in + xysp_pkg::step_type'(64));
   end

   // stage 2: gain multiply
   always_ff @(posedge clock) begin
      px2_ff  <= PW'(ex1_ff) * PW'($signed({1'b0, gain_ff}));
      py2_ff  <= PW'(ey1_ff) * PW'($signed({1'b0, gain_ff}));
      sin2_ff <= sin1_ff;
      cos2_ff <= cos1_ff;
   end

   // stage 3: round, shift by 8, saturate thrust
   always_comb begin
      tsum_x = px2_ff + T_ROUND;
      tsum_y = py2_ff + T_ROUND;
      tsat_x = saturate(tsum_x[PW-1:8]);
      tsat_y = saturate(tsum_y[PW-1:8]);
   end

   always_ff @(posedge clock) begin
      tx3_ff   <= tsat_x[DATA_BITS-1:0];
      ty3_ff   <= tsat_y[DATA_BITS-1:0];
      clip3_ff <= tsat_x[DATA_BITS] | tsat_y[DATA_BITS];
      sin3_ff  <= sin2_ff;
      cos3_ff  <= cos2_ff;
   end

   // stage 4: rotation products
   always_ff @(posedge clock) begin
      txc4_ff  <= RW'(tx3_ff) * RW'(cos3_ff);
      tys4_ff  <= RW'(ty3_ff) * RW'(sin3_ff);
      txs4_ff  <= RW'(tx3_ff) * RW'(sin3_ff);
      tyc4_ff  <= RW'(ty3_ff) * RW'(cos3_ff);
      clip4_ff <= clip3_ff;
   end

   // stage 5: sum, round, shift by 14, saturate
   always_comb begin
      csum_x   = CW'(txc4_ff) - CW'(tys4_ff) + C_ROUND;
      csum_y   = CW'(txs4_ff) + CW'(tyc4_ff) + C_ROUND;
      cshift_x = csum_x[CW-1:14];
      cshift_y = csum_y[CW-1:14];
      csat_x   = saturate(SW'(cshift_x));
      csat_y   = saturate(SW'(cshift_y));
   end

   always_ff @(posedge clock) begin
      cx5_ff   <= csat_x[DATA_BITS-1:0];
      cy5_ff   <= csat_y[DATA_BITS-1:0];
      clip5_ff <= clip4_ff | csat_x[DATA_BITS] | csat_y[DATA_BITS];
   end

   assign rsp_valid     = valid_ff[5];
   assign rsp_command_x = cx5_ff;
   assign rsp_command_y = cy5_ff;
   assign rsp_clipped   = clip5_ff;

endmodule

`default_nettype wire

/* dv/xy_speed_p_control_rotate_top_test.sv */
// ----------------------------------------------------------------------------
// xy_speed_p_control_rotate_top_test
// Self-checking bench for the 2D speed P controller with yaw rotation. Items
// go through a start/busy driver with random gaps. A predictor computes the
// scaled error, the table-based rotation, rounding and saturation, and queues
// the expected command. The monitor compares every rsp_valid strobe against
// the oldest entry. The gain register is rewritten between phases while the
// pipeline is empty: reset value, zero, one, full scale and a few others.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xy_speed_p_control_rotate_top_test;

   localparam int DATA_BITS = 16;
   localparam int ANGLE_BITS = 16;
   localparam longint CMD_MAX = 32767;
   localparam longint CMD_MIN = -32768;
   localparam logic [15:0] GAIN_AT_RESET = 16'd256;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 236;
   localparam int TAIL_CYCLES = 12;
   localparam int LIMIT_CYCLES = 300000;
   localparam int MAX_PRINTED = 40;

   // quarter wave, round(16384 * sin(k * pi / 128))
   localparam int SINE_Q14 [0:64] = '{
      0, 402, 804, 1205, 1606, 2006, 2404, 2801,
      3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
      6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
      9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
      11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
      13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
      15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
      16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
      16384
   };

   typedef struct packed {
      logic [DATA_BITS-1:0]  sp_x;
      logic [DATA_BITS-1:0]  sp_y;
      logic [DATA_BITS-1:0]  ms_x;
      logic [DATA_BITS-1:0]  ms_y;
      logic [ANGLE_BITS-1:0] yaw;
   } speed_item_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] cmd_x;
      logic [DATA_BITS-1:0] cmd_y;
      logic                 clip;
   } command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [DATA_BITS-1:0] req_setpoint_x = '0;
   logic signed [DATA_BITS-1:0] req_setpoint_y = '0;
   logic signed [DATA_BITS-1:0] req_measured_x = '0;
   logic signed [DATA_BITS-1:0] req_measured_y = '0;
   logic [ANGLE_BITS-1:0]       req_yaw_angle = '0;
   logic rsp_valid;
   logic signed [DATA_BITS-1:0] rsp_command_x;
   logic signed [DATA_BITS-1:0] rsp_command_y;
   logic rsp_clipped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [xysp_pkg::GAIN_BITS-1:0] csr_speed_gain = '0;

   speed_item_type pending_items [$];
   command_type    command_queue [$];
   logic [15:0] gain_model = GAIN_AT_RESET;
   logic        req_taken = 1'b0;
   logic        gain_written = 1'b0;
   logic        gaps_enabled = 1'b1;
   int          gap_left = 0;
   int          items_total = 0;
   int          results_seen = 0;
   int          clip_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;

   xy_speed_p_control_rotate_top #(
      .ANGLE_BITS(ANGLE_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_setpoint_x(req_setpoint_x),
      .req_setpoint_y(req_setpoint_y),
      .req_measured_x(req_measured_x),
      .req_measured_y(req_measured_y),
      .req_yaw_angle (req_yaw_angle),
      .rsp_valid     (rsp_valid),
      .rsp_command_x (rsp_command_x),
      .rsp_command_y (rsp_command_y),
      .rsp_clipped   (rsp_clipped),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_speed_gain(csr_speed_gain)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_q(input longint v);
      if (v > CMD_MAX) return CMD_MAX;
      if (v < CMD_MIN) return CMD_MIN;
      return v;
   endfunction

   function automatic longint sine_q14(input logic [7:0] step);
      longint mag;
      if (step[6]) mag = SINE_Q14[64 - step[5:0]];
      else mag = SINE_Q14[step[5:0]];
      return step[7] ? -mag : mag;
   endfunction

   function automatic command_type predict_command(input speed_item_type it,
                                                   input logic [15:0] gain);
      command_type r;
      longint     g, ex, ey, tx, ty, tx_c, ty_c, sn, cs, cx, cy, cx_c, cy_c;
      logic [7:0] step;
      g = gain;
      ex = longint'($signed(it.sp_x)) - longint'($signed(it.ms_x));
      ey = longint'($signed(it.sp_y)) - longint'($signed(it.ms_y));
      tx = (ex * g + 128) >>> 8;
      ty = (ey * g + 128) >>> 8;
      tx_c = clamp_q(tx);
      ty_c = clamp_q(ty);
      step = it.yaw[ANGLE_BITS-1 -: 8];
      sn = sine_q14(step);
      cs = sine_q14(step + 8'd64);
      cx = (tx_c * cs - ty_c * sn + 8192) >>> 14;
      cy = (tx_c * sn + ty_c * cs + 8192) >>> 14;
      cx_c = clamp_q(cx);
      cy_c = clamp_q(cy);
      r.cmd_x = cx_c[DATA_BITS-1:0];
      r.cmd_y = cy_c[DATA_BITS-1:0];
      r.clip = (tx != tx_c) || (ty != ty_c) || (cx != cx_c) || (cy != cy_c);
      return r;
   endfunction

   function automatic logic [15:0] extreme_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic speed_item_type random_speed_item();
      speed_item_type it;
      int             mode;
      mode = $urandom_range(0, 9);
      it.yaw = 16'($urandom);
      if (mode < 4) begin
         it.sp_x = 16'($urandom);
         it.sp_y = 16'($urandom);
         it.ms_x = 16'($urandom);
         it.ms_y = 16'($urandom);
      end else if (mode < 8) begin
         // tracking case: setpoint close to measured
         it.ms_x = 16'($urandom_range(0, 32767) - 16384);
         it.ms_y = 16'($urandom_range(0, 32767) - 16384);
         it.sp_x = it.ms_x + 16'($urandom_range(0, 4095) - 2048);
         it.sp_y = it.ms_y + 16'($urandom_range(0, 4095) - 2048);
      end else begin
         it.sp_x = extreme_value();
         it.sp_y = extreme_value();
         it.ms_x = extreme_value();
         it.ms_y = extreme_value();
         case ($urandom_range(0, 5))
            0: it.yaw = 16'h0000;
            1: it.yaw = 16'h4000;
            2: it.yaw = 16'h8000;
            3: it.yaw = 16'hC000;
            4: it.yaw = 16'hFFFF;
            default: ;
         endcase
      end
      return it;
   endfunction

   task automatic push_item(input logic [15:0] sx, input logic [15:0] sy,
                            input logic [15:0] mx, input logic [15:0] my,
                            input logic [15:0] yaw);
      speed_item_type it;
      it.sp_x = sx;
      it.sp_y = sy;
      it.ms_x = mx;
      it.ms_y = my;
      it.yaw = yaw;
      pending_items.push_back(it);
      items_total++;
   endtask

   task automatic queue_random_items(input int count);
      speed_item_type it;
      repeat (count) begin
         it = random_speed_item();
         push_item(it.sp_x, it.sp_y, it.ms_x, it.ms_y, it.yaw);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic write_speed_gain(input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_speed_gain <= value;
      do @(negedge clock); while (!gain_written);
      csr_valid <= 1'b0;
   endtask

   // driver: holds an item until start && !busy, then maybe idles
   always @(negedge clock) begin
      speed_item_type nxt;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !req_taken) begin
      end else if (gap_left != 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
         nxt = pending_items.pop_front();
         req_setpoint_x <= nxt.sp_x;
         req_setpoint_y <= nxt.sp_y;
         req_measured_x <= nxt.ms_x;
         req_measured_y <= nxt.ms_y;
         req_yaw_angle <= nxt.yaw;
         start <= 1'b1;
         if (gaps_enabled && $urandom_range(0, 4) == 0)
            gap_left <= $urandom_range(1, 14);
      end else begin
         start <= 1'b0;
      end
   end

   // monitor, predictor and gain register shadow
   always @(posedge clock) begin
      command_type    want;
      speed_item_type cur;
      if (reset) begin
         gain_model <= GAIN_AT_RESET;
         req_taken <= 1'b0;
         gain_written <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         gain_written <= csr_valid && csr_ready;
         if (csr_valid && csr_ready)
            gain_model <= csr_speed_gain;
         if (rsp_valid) begin
            if (command_queue.size() == 0) begin
               report_mismatch("result with no item outstanding", rsp_command_x, 0);
            end else begin
               want = command_queue.pop_front();
               if (rsp_command_x !== want.cmd_x)
                  report_mismatch("command_x", rsp_command_x, $signed(want.cmd_x));
               if (rsp_command_y !== want.cmd_y)
                  report_mismatch("command_y", rsp_command_y, $signed(want.cmd_y));
               if (rsp_clipped !== want.clip)
                  report_mismatch("clipped", rsp_clipped, want.clip);
               results_seen <= results_seen + 1;
               if (want.clip)
                  clip_count <= clip_count + 1;
            end
         end
         if (start && !busy) begin
            cur.sp_x = req_setpoint_x;
            cur.sp_y = req_setpoint_y;
            cur.ms_x = req_measured_x;
            cur.ms_y = req_measured_y;
            cur.yaw = req_yaw_angle;
            command_queue.push_back(predict_command(cur, gain_model));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("ERROR: no progress, run stopped after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [15:0] gain_plan [0:NUM_PHASES-2];
      gain_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0080, 16'h0000, 16'h0280, 16'h0100};
      gain_plan[4] = 16'($urandom);

      // directed items, run at the reset gain
      push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_item(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000);
      push_item(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      push_item(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_item(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
      push_item(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_item(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
      push_item(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      push_item(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
      push_item(16'h0100, 16'h0200, 16'h0000, 16'h0000, 16'h2000);
      // fine yaw bits set, dropped by the step lookup
      push_item(16'h0100, 16'h0200, 16'h0000, 16'h0000, 16'h00FF);
      push_item(16'h0100, 16'h0200, 16'h0000, 16'h0000, 16'h40FF);
      // thrust in range, rotated sum saturates
      push_item(16'h6400, 16'h9C00, 16'h0000, 16'h0000, 16'h2000);
      push_item(16'h6400, 16'h6400, 16'h0000, 16'h0000, 16'hE000);
      push_item(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h4000);
      push_item(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h1234);
      push_item(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hA5A5);
      push_item(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h5A5A);
      push_item(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h6000);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0)
            write_speed_gain(gain_plan[phase-1]);
         @(posedge clock);
         gaps_enabled = (phase < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         queue_random_items(ITEMS_PER_PHASE);
         do @(negedge clock); while (results_seen != items_total);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (command_queue.size() != 0)
         report_mismatch("items left without a result", command_queue.size(), 0);
      $display("Checked %0d items over %0d gain settings incl. 0, 1 and full scale;",
               items_total, NUM_PHASES);
      $display("%0d results saturated, %0d mismatches.", clip_count, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* xy_speed_p_control_rotate_top.f */
src/xysp_pkg.sv
src/xy_speed_p_control_rotate_top.sv
dv/xy_speed_p_control_rotate_top_test.sv
